[hw/rtl/plob_pkg.sv]
// ----------------------------------------------------------------------------
// plob_pkg
// Shared types, codes and sizes for the price-level order book
// ----------------------------------------------------------------------------
package plob_pkg;

    localparam int BOOK_DEPTH  = 1024;
    localparam int IDX_W       = $clog2(BOOK_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int PRICE_W     = 32;
    localparam int QTY_W       = 48;
    localparam int ID_W        = 48;
    localparam int LEVEL_IDX_W = 10;
    localparam int SIDE_CNT_W  = 11;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_SNAPSHOT = 2'd1,
        CMD_DIFF     = 2'd2,
        CMD_UNUSED   = 2'd3
    } plob_cmd_t;

    typedef enum logic [1:0] {
        ST_APPLIED = 2'd0,
        ST_STALE   = 2'd1,
        ST_GAP     = 2'd2,
        ST_FULL    = 2'd3
    } plob_status_t;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_INSERTED = 2'd1,
        ACT_REPLACED = 2'd2,
        ACT_DELETED  = 2'd3
    } plob_action_t;

    typedef enum logic [1:0] {
        K_CLEAR = 2'd0,
        K_PASS  = 2'd1,
        K_APPLY = 2'd2
    } plob_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE   = 3'd0,
        BK_SCAN   = 3'd1,
        BK_DECIDE = 3'd2,
        BK_SHIFT  = 3'd3,
        BK_WNEW   = 3'd4
    } plob_bk_state_t;

    typedef struct packed {
        plob_kind_t          kind;
        plob_status_t        status;
        logic                is_bid;
        logic [PRICE_W-1:0]  price;
        logic [QTY_W-1:0]    quantity;
        logic [ID_W-1:0]     cur_id;
    } plob_item_t;

endpackage

[hw/rtl/plob_front.sv]
// ----------------------------------------------------------------------------
// plob_front
// Takes transactions, runs the sequence checks and keeps the update id
// ----------------------------------------------------------------------------
module plob_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       q_full,
    input  logic [1:0]                 cmd,
    input  logic                       is_bid,
    input  logic [plob_pkg::PRICE_W-1:0] price,
    input  logic [plob_pkg::QTY_W-1:0] quantity,
    input  logic [plob_pkg::ID_W-1:0]  first_update_id,
    input  logic [plob_pkg::ID_W-1:0]  final_update_id,
    input  logic [plob_pkg::ID_W-1:0]  event_time_ms,
    input  logic                       end_of_message,
    output logic                       push,
    output plob_pkg::plob_item_t       item
);
    import plob_pkg::*;

    logic [ID_W-1:0] stored_id_reg;
    logic [ID_W-1:0] stored_id_next;
    logic [ID_W-1:0] event_time_reg;
    logic [ID_W-1:0] event_time_next;
    logic            stale;
    logic            gap;

    assign push  = start & ~q_full;
    assign stale = final_update_id < stored_id_reg;
    assign gap   = {1'b0, first_update_id} > ({1'b0, stored_id_reg} + (ID_W+1)'(1));

    always_comb
    begin
        stored_id_next  = stored_id_reg;
        event_time_next = event_time_reg;
        item.kind       = K_PASS;
        item.status     = ST_APPLIED;
        item.is_bid     = is_bid;
        item.price      = price;
        item.quantity   = quantity;
        unique case (plob_cmd_t'(cmd))
            CMD_CLEAR:
            begin
                item.kind      = K_CLEAR;
                stored_id_next = final_update_id;
            end
            CMD_SNAPSHOT:
            begin
                item.kind = K_APPLY;
            end
            CMD_DIFF:
            begin
                if (stale)
                begin
                    item.status = ST_STALE;
                end
                else if (gap)
                begin
                    item.status = ST_GAP;
                end
                else
                begin
                    item.kind = K_APPLY;
                    if (end_of_message)
                    begin
                        stored_id_next  = final_update_id;
                        event_time_next = event_time_ms;
                    end
                end
            end
            default:
            begin
                item.kind = K_PASS;
            end
        endcase
        item.cur_id = stored_id_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_id_reg  <= '0;
            event_time_reg <= '0;
        end
        else if (push)
        begin
            stored_id_reg  <= stored_id_next;
            event_time_reg <= event_time_next;
        end
    end

endmodule

[hw/rtl/plob_queue.sv]
// ----------------------------------------------------------------------------
// plob_queue
// Two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module plob_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  plob_pkg::plob_item_t push_item,
    input  logic                 pop,
    output plob_pkg::plob_item_t pop_item,
    output logic                 full,
    output logic                 empty
);
    import plob_pkg::*;

    plob_item_t  slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign empty    = cnt_reg == 2'd0;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

[hw/rtl/plob_back.sv]
// ----------------------------------------------------------------------------
// plob_back
// Book memories, level search and shift, result register
// ----------------------------------------------------------------------------
module plob_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  plob_pkg::plob_item_t                q_item,
    output logic                                pop,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [1:0]                          action,
    output logic [plob_pkg::LEVEL_IDX_W-1:0]    level_index,
    output logic [plob_pkg::SIDE_CNT_W-1:0]     side_count,
    output logic [plob_pkg::ID_W-1:0]           current_update_id
);
    import plob_pkg::*;

    logic [PRICE_W-1:0] price_mem [2*BOOK_DEPTH];
    logic [QTY_W-1:0]   qty_mem   [2*BOOK_DEPTH];

    plob_bk_state_t     state_reg, state_next;
    plob_item_t         item_reg, item_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   r_reg, r_next;
    logic               found_reg, found_next;
    logic [CNT_W-1:0]   ask_cnt_reg, ask_cnt_next;
    logic [CNT_W-1:0]   bid_cnt_reg, bid_cnt_next;

    logic               done_reg, done_next;
    logic [1:0]         status_reg, status_next;
    logic [1:0]         action_reg, action_next;
    logic [CNT_W-1:0]   index_reg, index_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ID_W-1:0]    id_reg, id_next;

    logic               rd_side;
    logic [CNT_W-1:0]   rd_idx;
    logic [PRICE_W-1:0] rd_price_reg;
    logic [QTY_W-1:0]   rd_qty_reg;
    logic               wr_en;
    logic [CNT_W-1:0]   wr_idx;
    logic [PRICE_W-1:0] wr_price;
    logic [QTY_W-1:0]   wr_qty;

    logic               cnt_wr;
    logic [CNT_W-1:0]   cnt_val;
    logic [CNT_W-1:0]   n;
    logic [CNT_W-1:0]   qn;
    logic               stop;

    assign n    = item_reg.is_bid ? bid_cnt_reg : ask_cnt_reg;
    assign qn   = q_item.is_bid ? bid_cnt_reg : ask_cnt_reg;
    assign stop = item_reg.is_bid ? (rd_price_reg <= item_reg.price)
                                  : (rd_price_reg >= item_reg.price);

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        pos_next     = pos_reg;
        r_next       = r_reg;
        found_next   = found_reg;
        ask_cnt_next = ask_cnt_reg;
        bid_cnt_next = bid_cnt_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        action_next  = action_reg;
        index_next   = index_reg;
        count_next   = count_reg;
        id_next      = id_reg;
        pop          = 1'b0;
        rd_side      = item_reg.is_bid;
        rd_idx       = '0;
        wr_en        = 1'b0;
        wr_idx       = '0;
        wr_price     = item_reg.price;
        wr_qty       = item_reg.quantity;
        cnt_wr       = 1'b0;
        cnt_val      = n;
        unique case (state_reg)
            BK_IDLE:
            begin
                rd_side = q_item.is_bid;
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    item_next = q_item;
                    id_next   = q_item.cur_id;
                    unique case (q_item.kind)
                        K_CLEAR:
                        begin
                            ask_cnt_next = '0;
                            bid_cnt_next = '0;
                            done_next    = 1'b1;
                            status_next  = ST_APPLIED;
                            action_next  = ACT_NONE;
                            index_next   = '0;
                            count_next   = '0;
                        end
                        K_APPLY:
                        begin
                            pos_next = '0;
                            if (qn == '0)
                            begin
                                found_next = 1'b0;
                                state_next = BK_DECIDE;
                            end
                            else
                            begin
                                state_next = BK_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = q_item.status;
                            action_next = ACT_NONE;
                            index_next  = '0;
                            count_next  = qn;
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                if (stop)
                begin
                    found_next = rd_price_reg == item_reg.price;
                    state_next = BK_DECIDE;
                end
                else
                begin
                    pos_next = pos_reg + CNT_W'(1);
                    rd_idx   = pos_reg + CNT_W'(1);
                    if (pos_reg + CNT_W'(1) == n)
                    begin
                        found_next = 1'b0;
                        state_next = BK_DECIDE;
                    end
                end
            end
            BK_DECIDE:
            begin
                index_next  = pos_reg;
                status_next = ST_APPLIED;
                action_next = ACT_NONE;
                count_next  = n;
                state_next  = BK_IDLE;
                if (found_reg)
                begin
                    if (item_reg.quantity == '0)
                    begin
                        if (pos_reg == n - CNT_W'(1))
                        begin
                            cnt_wr      = 1'b1;
                            cnt_val     = n - CNT_W'(1);
                            done_next   = 1'b1;
                            action_next = ACT_DELETED;
                            count_next  = n - CNT_W'(1);
                        end
                        else
                        begin
                            rd_idx     = pos_reg + CNT_W'(1);
                            r_next     = pos_reg + CNT_W'(1);
                            state_next = BK_SHIFT;
                        end
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_idx      = pos_reg;
                        done_next   = 1'b1;
                        action_next = ACT_REPLACED;
                    end
                end
                else if (item_reg.quantity == '0)
                begin
                    done_next = 1'b1;
                end
                else if (n >= CNT_W'(BOOK_DEPTH))
                begin
                    done_next   = 1'b1;
                    status_next = ST_FULL;
                end
                else if (pos_reg == n)
                begin
                    wr_en       = 1'b1;
                    wr_idx      = pos_reg;
                    cnt_wr      = 1'b1;
                    cnt_val     = n + CNT_W'(1);
                    done_next   = 1'b1;
                    action_next = ACT_INSERTED;
                    count_next  = n + CNT_W'(1);
                end
                else
                begin
                    rd_idx     = n - CNT_W'(1);
                    r_next     = n - CNT_W'(1);
                    state_next = BK_SHIFT;
                end
            end
            BK_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_price = rd_price_reg;
                wr_qty   = rd_qty_reg;
                if (found_reg)
                begin
                    wr_idx = r_reg - CNT_W'(1);
                    if (r_reg == n - CNT_W'(1))
                    begin
                        cnt_wr      = 1'b1;
                        cnt_val     = n - CNT_W'(1);
                        done_next   = 1'b1;
                        status_next = ST_APPLIED;
                        action_next = ACT_DELETED;
                        index_next  = pos_reg;
                        count_next  = n - CNT_W'(1);
                        state_next  = BK_IDLE;
                    end
                    else
                    begin
                        rd_idx = r_reg + CNT_W'(1);
                        r_next = r_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    wr_idx = r_reg + CNT_W'(1);
                    if (r_reg == pos_reg)
                    begin
                        state_next = BK_WNEW;
                    end
                    else
                    begin
                        rd_idx = r_reg - CNT_W'(1);
                        r_next = r_reg - CNT_W'(1);
                    end
                end
            end
            BK_WNEW:
            begin
                wr_en       = 1'b1;
                wr_idx      = pos_reg;
                cnt_wr      = 1'b1;
                cnt_val     = n + CNT_W'(1);
                done_next   = 1'b1;
                status_next = ST_APPLIED;
                action_next = ACT_INSERTED;
                index_next  = pos_reg;
                count_next  = n + CNT_W'(1);
                state_next  = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        if (cnt_wr)
        begin
            if (item_reg.is_bid)
            begin
                bid_cnt_next = cnt_val;
            end
            else
            begin
                ask_cnt_next = cnt_val;
            end
        end
    end

    // book storage, side selects the upper address bit
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            price_mem[{item_reg.is_bid, wr_idx[IDX_W-1:0]}] <= wr_price;
            qty_mem[{item_reg.is_bid, wr_idx[IDX_W-1:0]}]   <= wr_qty;
        end
        rd_price_reg <= price_mem[{rd_side, rd_idx[IDX_W-1:0]}];
        rd_qty_reg   <= qty_mem[{rd_side, rd_idx[IDX_W-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        pos_reg    <= pos_next;
        r_reg      <= r_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        action_reg <= action_next;
        index_reg  <= index_next;
        count_reg  <= count_next;
        id_reg     <= id_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            ask_cnt_reg <= '0;
            bid_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ask_cnt_reg <= ask_cnt_next;
            bid_cnt_reg <= bid_cnt_next;
            done_reg    <= done_next;
        end
    end

    assign done              = done_reg;
    assign status            = status_reg;
    assign action            = action_reg;
    assign level_index       = LEVEL_IDX_W'(index_reg);
    assign side_count        = SIDE_CNT_W'(count_reg);
    assign current_update_id = id_reg;

endmodule

[hw/rtl/price_level_order_book.sv]
// ----------------------------------------------------------------------------
// price_level_order_book
// Two sorted price-level books (asks ascending, bids descending) with
// snapshot load and sequence-checked diff updates
// ----------------------------------------------------------------------------
//  channel   handshake              fields
//  input     start, busy            cmd, is_bid, price, quantity,
//                                   first_update_id, final_update_id,
//                                   event_time_ms, end_of_message
//  result    done (one-cycle)       status, action, level_index,
//                                   side_count, current_update_id
//
//  clear, stale, gap and unused commands are answered from the idle state as
//  they are popped; a level is searched over the entries of its side, then
//  decided, and moved entries (and the new entry on insert) are written one
//  by one through the single read and write port of the book memory
//  reset clears the counts and the update id; book memories are not cleared
//  busy is high while the two-entry queue is full; results cannot be held off
// ----------------------------------------------------------------------------
module price_level_order_book (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          cmd,
    input  logic                                is_bid,
    input  logic [plob_pkg::PRICE_W-1:0]        price,
    input  logic [plob_pkg::QTY_W-1:0]          quantity,
    input  logic [plob_pkg::ID_W-1:0]           first_update_id,
    input  logic [plob_pkg::ID_W-1:0]           final_update_id,
    input  logic [plob_pkg::ID_W-1:0]           event_time_ms,
    input  logic                                end_of_message,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [1:0]                          action,
    output logic [plob_pkg::LEVEL_IDX_W-1:0]    level_index,
    output logic [plob_pkg::SIDE_CNT_W-1:0]     side_count,
    output logic [plob_pkg::ID_W-1:0]           current_update_id
);
    import plob_pkg::*;

    plob_item_t push_item;
    plob_item_t pop_item;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;

    assign busy = q_full;

    plob_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .q_full          (q_full),
        .cmd             (cmd),
        .is_bid          (is_bid),
        .price           (price),
        .quantity        (quantity),
        .first_update_id (first_update_id),
        .final_update_id (final_update_id),
        .event_time_ms   (event_time_ms),
        .end_of_message  (end_of_message),
        .push            (push),
        .item            (push_item)
    );

    plob_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    plob_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_item            (pop_item),
        .pop               (pop),
        .done              (done),
        .status            (status),
        .action            (action),
        .level_index       (level_index),
        .side_count        (side_count),
        .current_update_id (current_update_id)
    );

endmodule

[hw/rtl/plob_checker.sv]
// ----------------------------------------------------------------------------
// plob_checker
// Port-level checks on results of the order book
// ----------------------------------------------------------------------------
module plob_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                done,
    input  logic [1:0]                          status,
    input  logic [1:0]                          action,
    input  logic [plob_pkg::LEVEL_IDX_W-1:0]    level_index,
    input  logic [plob_pkg::SIDE_CNT_W-1:0]     side_count
);
    import plob_pkg::*;

    // dropped transactions never change the book
    a_drop_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_APPLIED |-> action == ACT_NONE)
        else $error("dropped transaction reports an action");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> side_count == SIDE_CNT_W'(BOOK_DEPTH))
        else $error("full drop without a full side");

    a_insert_index: assert property (@(posedge clk) disable iff (!rst_n)
        done && action == ACT_INSERTED
            |-> SIDE_CNT_W'(level_index) < side_count)
        else $error("insert position beyond side count");

    a_delete_index: assert property (@(posedge clk) disable iff (!rst_n)
        done && action == ACT_DELETED
            |-> SIDE_CNT_W'(level_index) <= side_count)
        else $error("delete position beyond side count");

endmodule

bind price_level_order_book plob_checker u_plob_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .done        (done),
    .status      (status),
    .action      (action),
    .level_index (level_index),
    .side_count  (side_count)
);
